// ===== hw/rtl/rk4d_pkg.sv =====
`default_nettype none

package rk4d_pkg;

   // Run length limit and the width of the point counter that follows from it.
   localparam int MAX_POINTS = 8192;
   localparam int CNT_W      = $clog2(MAX_POINTS);
   localparam int INDEX_W    = 13;

   // Serial multiplier: magnitude operand, unsigned operand, full product.
   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Serial divide-by-six unit takes the product with the low sixteen bits dropped.
   localparam int DIV_W = MUL_P_W - 16;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DECAY_RATE = 2'd0;
   localparam logic [1:0] CSR_STEP_SIZE  = 2'd1;
   localparam logic [1:0] CSR_FINAL_TIME = 2'd2;

   // Item modes.
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   // Register values after reset.
   localparam logic [19:0]        DECAY_RATE_RST = 20'd19661;
   localparam logic [30:0]        STEP_SIZE_RST  = 31'd32768;
   localparam logic signed [31:0] FINAL_TIME_RST = 32'sd327680;

   // Handshake between the sequencer and a serial unit.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rk4d_mul.sv =====
`default_nettype none

module rk4d_mul (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire  [rk4d_pkg::MUL_A_W-1:0]     a,
   input  wire  [rk4d_pkg::MUL_B_W-1:0]     b,
   output rk4d_pkg::unit_status_type        status,
   output logic [rk4d_pkg::MUL_P_W-1:0]     product
);
   import rk4d_pkg::*;

   localparam int CW = $clog2(MUL_B_W);

   logic [MUL_A_W-1:0] a_ff;
   logic [MUL_A_W-1:0] hi_ff;
   logic [MUL_A_W-1:0] hi_in;
   logic [MUL_B_W-1:0] lo_ff;
   logic [MUL_B_W-1:0] lo_in;
   logic [MUL_A_W:0]   sum;
   logic [CW-1:0]      cnt_ff;
   logic               busy_ff;
   logic               done_ff;

   // One multiplier bit per cycle: add the multiplicand, then shift the pair right.
   always_comb begin
      sum   = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : '0);
      hi_in = sum[MUL_A_W:1];
      lo_in = {sum[0], lo_ff[MUL_B_W-1:1]};
   end

   // Sequencing of the bit count.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(MUL_B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand and partial product shift registers.
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= a;
         hi_ff <= '0;
         lo_ff <= b;
      end else if (busy_ff) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign product     = {hi_ff, lo_ff};
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rk4d_div6.sv =====
`default_nettype none

module rk4d_div6 (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   input  wire  [rk4d_pkg::DIV_W-1:0]    dividend,
   output rk4d_pkg::unit_status_type     status,
   output logic [rk4d_pkg::DIV_W-1:0]    quotient
);
   import rk4d_pkg::*;

   localparam int CW = $clog2(DIV_W);

   logic [DIV_W-1:0] x_ff;
   logic [2:0]       rem_ff;
   logic [3:0]       trial;
   logic             qbit;
   logic [2:0]       rem_in;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   // Restoring division by six, one dividend bit per cycle from the top.
   always_comb begin
      trial = {rem_ff, x_ff[DIV_W-1]};
      qbit  = (trial >= 4'd6);
      rem_in = qbit ? 3'(trial - 4'd6) : trial[2:0];
   end

   // Sequencing of the bit count.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Dividend shifts out at the top while quotient bits fill from the bottom.
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         x_ff   <= {x_ff[DIV_W-2:0], qbit};
         rem_ff <= rem_in;
      end
   end

   assign quotient    = x_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rk4_decay_integrator.sv =====
// Channel | Direction | Ports                                   | Transfer when
// req     | in        | req_mode, req_start_time, req_start_value | req_valid & !req_stall
// rsp     | out       | rsp_point_time/value/index, rsp_last      | rsp_valid & !rsp_stall
// csr     | in        | csr_index, csr_data                     | csr_write
//
// A load goes from the idle state straight to the emit state. A step makes eight passes
// of the shared bit-serial multiplier (four slopes, three stage values and the weighted
// sum) and one pass of the serial divide-by-six unit.
// Reset is synchronous; it clears the run (finished, at time and value zero) and
// restores the register defaults. The input is stalled while an item is being worked;
// a finished result waits in the output register for as long as rsp_stall holds.
`default_nettype none

module rk4_decay_integrator (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire                           req_mode,
   input  wire  signed [31:0]            req_start_time,
   input  wire  signed [31:0]            req_start_value,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic signed [31:0]            rsp_point_time,
   output logic signed [31:0]            rsp_point_value,
   output logic [rk4d_pkg::INDEX_W-1:0]  rsp_point_index,
   output logic                          rsp_last,
   input  wire                           csr_write,
   input  wire  [1:0]                    csr_index,
   input  wire  [31:0]                   csr_data
);
   import rk4d_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SLOPE_GO,
      S_SLOPE_WAIT,
      S_STAGE_GO,
      S_STAGE_WAIT,
      S_COMB_GO,
      S_COMB_WAIT,
      S_DIV_GO,
      S_DIV_WAIT,
      S_MARK,
      S_EMIT
   } state_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [53:0] v);
      logic signed [31:0] r;
      if (v > 54'sd2147483647)       r = 32'sh7FFFFFFF;
      else if (v < -54'sd2147483648) r = 32'sh80000000;
      else                           r = v[31:0];
      return r;
   endfunction

   state_type                 state_ff;
   logic [19:0]               decay_rate_ff;
   logic [30:0]               step_size_ff;
   logic signed [31:0]        final_time_ff;
   logic signed [31:0]        cur_time_ff;
   logic signed [31:0]        cur_value_ff;
   logic [CNT_W-1:0]          count_ff;
   logic                      run_done_ff;
   logic [30:0]               paso_ff;
   logic signed [31:0]        cs_ff;
   logic signed [31:0]        k_ff;
   logic signed [35:0]        sum_ff;
   logic [1:0]                stage_ff;
   logic                      rsp_valid_ff;
   logic signed [31:0]        rsp_time_ff;
   logic signed [31:0]        rsp_value_ff;
   logic [INDEX_W-1:0]        rsp_index_ff;
   logic                      rsp_last_ff;

   logic                      can_cont;
   logic signed [32:0]        diff;
   logic [30:0]               paso_sel;
   logic [31:0]               cs_mag;
   logic [31:0]               k_mag;
   logic [35:0]               sum_mag;
   logic                      mul_start;
   logic [MUL_A_W-1:0]        mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   unit_status_type           mul_status;
   logic [MUL_P_W-1:0]        mul_product;
   logic                      div_start;
   unit_status_type           div_status;
   logic [DIV_W-1:0]          div_q;
   logic [51:0]               slope_round;
   logic [35:0]               kmag;
   logic signed [31:0]        k_new;
   logic signed [35:0]        k_ext;
   logic signed [35:0]        sum_in;
   logic [63:0]               stage_round;
   logic [47:0]               stage_r;
   logic signed [53:0]        stage_cand;
   logic [MUL_P_W-1:0]        comb_round;
   logic signed [53:0]        value_cand;

   // Run state checks and the clamped step length.
   always_comb begin
      can_cont = (cur_time_ff < final_time_ff) && (count_ff < CNT_W'(MAX_POINTS - 1));
      diff     = {final_time_ff[31], final_time_ff} - {cur_time_ff[31], cur_time_ff};
      paso_sel = ($signed({2'b00, step_size_ff}) < diff) ? step_size_ff : diff[30:0];
   end

   // Operand magnitudes for the unsigned multiplier.
   always_comb begin
      cs_mag  = cs_ff[31] ? (~cs_ff + 32'd1) : cs_ff;
      k_mag   = k_ff[31] ? (~k_ff + 32'd1) : k_ff;
      sum_mag = sum_ff[35] ? (~sum_ff + 36'd1) : sum_ff;
   end

   // Multiplier operand selection by phase.
   always_comb begin
      mul_start = (state_ff == S_SLOPE_GO) || (state_ff == S_STAGE_GO) ||
                  (state_ff == S_COMB_GO);
      div_start = (state_ff == S_DIV_GO);
      unique case (state_ff)
         S_SLOPE_GO: begin
            mul_a = {4'b0, cs_mag};
            mul_b = {12'b0, decay_rate_ff};
         end
         S_STAGE_GO: begin
            mul_a = {4'b0, k_mag};
            mul_b = {1'b0, paso_ff};
         end
         default: begin
            mul_a = sum_mag;
            mul_b = {1'b0, paso_ff};
         end
      endcase
   end

   // Slope: negated, rounded product of stage value and rate, saturated.
   always_comb begin
      slope_round = mul_product[51:0] + 52'h8000;
      kmag        = slope_round[51:16];
      if (cs_ff[31]) begin
         k_new = (kmag > 36'h07FFFFFFF) ? 32'sh7FFFFFFF : kmag[31:0];
      end else begin
         k_new = (kmag > 36'h080000000) ? 32'sh80000000 : (~kmag[31:0] + 32'd1);
      end
      k_ext  = 36'(k_new);
      sum_in = ((stage_ff == 2'd1) || (stage_ff == 2'd2)) ? sum_ff + (k_ext <<< 1)
                                                         : sum_ff + k_ext;
   end

   // Next stage value: half step for the middle slopes, full step for the last.
   always_comb begin
      if (stage_ff < 2'd2) begin
         stage_round = mul_product[63:0] + 64'h10000;
         stage_r     = {1'b0, stage_round[63:17]};
      end else begin
         stage_round = mul_product[63:0] + 64'h8000;
         stage_r     = stage_round[63:16];
      end
      stage_cand = k_ff[31] ? 54'(cur_value_ff) - $signed({6'b0, stage_r})
                            : 54'(cur_value_ff) + $signed({6'b0, stage_r});
   end

   // Weighted sum times step, rounded, divided by six in the serial unit.
   always_comb begin
      comb_round = mul_product + MUL_P_W'(196608);
      value_cand = sum_ff[35] ? 54'(cur_value_ff) - $signed({2'b0, div_q})
                              : 54'(cur_value_ff) + $signed({2'b0, div_q});
   end

   rk4d_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .status  (mul_status),
      .product (mul_product)
   );

   rk4d_div6 u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (comb_round[MUL_P_W-1:16]),
      .status   (div_status),
      .quotient (div_q)
   );

   // Sequencer, run state, registers and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         decay_rate_ff <= DECAY_RATE_RST;
         step_size_ff  <= STEP_SIZE_RST;
         final_time_ff <= FINAL_TIME_RST;
         cur_time_ff   <= '0;
         cur_value_ff  <= '0;
         count_ff      <= '0;
         run_done_ff   <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_DECAY_RATE: decay_rate_ff <= csr_data[19:0];
               CSR_STEP_SIZE:  step_size_ff  <= csr_data[30:0];
               CSR_FINAL_TIME: final_time_ff <= csr_data;
               default: ;
            endcase
         end

         // The output register empties on a transfer unless a new point replaces it.
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_mode == MODE_LOAD) begin
                     cur_time_ff  <= req_start_time;
                     cur_value_ff <= req_start_value;
                     count_ff     <= '0;
                     run_done_ff  <= !(req_start_time < final_time_ff);
                     state_ff     <= S_EMIT;
                  end else if (run_done_ff || !can_cont) begin
                     run_done_ff <= 1'b1;
                  end else begin
                     paso_ff  <= paso_sel;
                     cs_ff    <= cur_value_ff;
                     sum_ff   <= '0;
                     stage_ff <= 2'd0;
                     state_ff <= S_SLOPE_GO;
                  end
               end
            end
            S_SLOPE_GO: state_ff <= S_SLOPE_WAIT;
            S_SLOPE_WAIT: begin
               if (mul_status.done) begin
                  k_ff   <= k_new;
                  sum_ff <= sum_in;
                  state_ff <= (stage_ff == 2'd3) ? S_COMB_GO : S_STAGE_GO;
               end
            end
            S_STAGE_GO: state_ff <= S_STAGE_WAIT;
            S_STAGE_WAIT: begin
               if (mul_status.done) begin
                  cs_ff    <= sat32(stage_cand);
                  stage_ff <= stage_ff + 2'd1;
                  state_ff <= S_SLOPE_GO;
               end
            end
            S_COMB_GO: state_ff <= S_COMB_WAIT;
            S_COMB_WAIT: begin
               if (mul_status.done) begin
                  state_ff <= S_DIV_GO;
               end
            end
            S_DIV_GO: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (div_status.done) begin
                  cur_value_ff <= sat32(value_cand);
                  cur_time_ff  <= cur_time_ff + $signed({1'b0, paso_ff});
                  count_ff     <= count_ff + 1'b1;
                  state_ff     <= S_MARK;
               end
            end
            S_MARK: begin
               run_done_ff <= (paso_ff == '0) || !can_cont;
               state_ff    <= S_EMIT;
            end
            S_EMIT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_time_ff  <= cur_time_ff;
                  rsp_value_ff <= cur_value_ff;
                  rsp_index_ff <= INDEX_W'(count_ff);
                  rsp_last_ff  <= run_done_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_time  = rsp_time_ff;
   assign rsp_point_value = rsp_value_ff;
   assign rsp_point_index = rsp_index_ff;
   assign rsp_last        = rsp_last_ff;

   // The shared multiplier is never restarted while a product is in progress.
   assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_status.busy)
      else $error("multiplier restarted while busy");

   // A finished product only arrives while the sequencer is waiting for one.
   assert property (@(posedge clock) disable iff (reset)
      mul_status.done |-> (state_ff == S_SLOPE_WAIT || state_ff == S_STAGE_WAIT ||
                           state_ff == S_COMB_WAIT))
      else $error("product arrived outside a wait phase");

   // A step never carries time past the end time.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> (cur_time_ff <= final_time_ff))
      else $error("step overshot the end time");

   // The point count stays below the run limit.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS - 1))
      else $error("point count beyond the run limit");

endmodule

`default_nettype wire
